// ----- hw/rtl/mhp_pkg.sv -----
// Package for the MOT header parser: parse phases, result job record, constants.
// Used by the front end, queue, back end and top level; depends on nothing.
`default_nettype none

package mhp_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [5:0]  NameParamId = 6'd12;
  localparam logic [14:0] NameSlotEnd = 15'd64;
  localparam logic [15:0] CoreBytes   = 16'd7;
  localparam logic [5:0]  LimitReset  = 6'd63;

  // parameter length indicator (top two bits of a parameter byte)
  localparam logic [1:0] PliNone  = 2'd0;
  localparam logic [1:0] PliOne   = 2'd1;
  localparam logic [1:0] PliFour  = 2'd2;
  localparam logic [1:0] PliVar   = 2'd3;

  typedef enum logic [2:0] {
    PhParam   = 3'd0,
    PhLen1    = 3'd1,
    PhLen2    = 3'd2,
    PhCharset = 3'd3,
    PhName    = 3'd4,
    PhSkip    = 3'd5
  } phase_e;

  // everything one header byte hands to the output side
  typedef struct packed {
    logic        has_name;
    logic        has_sum;
    logic [7:0]  name_char;
    logic [3:0]  char_set;
    logic [27:0] body_size;
    logic [12:0] header_size;
    logic [5:0]  content_type;
    logic [8:0]  content_subtype;
  } job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mhp_front.sv -----
// Front end of the MOT header parser: gathers core fields, walks extension
// parameters and turns each accepted byte into at most one job. Uses mhp_pkg.
`default_nettype none

module mhp_front import mhp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       limit_we_i,
  input  wire logic [5:0] limit_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] header_byte_i,
  input  wire logic       segment_end_i,
  output logic            job_valid_o,
  output job_t            job_o
);

  logic [5:0]  limit_q;
  logic [15:0] pos_q, pos_d;
  phase_e      phase_q, phase_d;
  logic [14:0] skip_q, skip_d;
  logic [14:0] plen_q, plen_d;
  logic        is_name_q, is_name_d;
  logic [14:0] nidx_q, nidx_d;
  logic [3:0]  cset_q, cset_d;
  logic [27:0] body_q, body_d;
  logic [12:0] hsize_q, hsize_d;
  logic [5:0]  ctype_q, ctype_d;
  logic [8:0]  csub_q, csub_d;
  logic        stop_q, stop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LimitReset;
      pos_q     <= '0;
      phase_q   <= PhParam;
      skip_q    <= '0;
      plen_q    <= '0;
      is_name_q <= 1'b0;
      nidx_q    <= '0;
      cset_q    <= '0;
      body_q    <= '0;
      hsize_q   <= '0;
      ctype_q   <= '0;
      csub_q    <= '0;
      stop_q    <= 1'b0;
    end else begin
      if (limit_we_i) begin
        limit_q <= limit_i;
      end
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      plen_q    <= plen_d;
      is_name_q <= is_name_d;
      nidx_q    <= nidx_d;
      cset_q    <= cset_d;
      body_q    <= body_d;
      hsize_q   <= hsize_d;
      ctype_q   <= ctype_d;
      csub_q    <= csub_d;
      stop_q    <= stop_d;
    end
  end

  always_comb begin
    logic [14:0] len_new;
    logic [14:0] nidx_inc;
    logic [14:0] skip_dec;
    logic        data_start;
    logic        emit;

    pos_d     = pos_q;
    phase_d   = phase_q;
    skip_d    = skip_q;
    plen_d    = plen_q;
    is_name_d = is_name_q;
    nidx_d    = nidx_q;
    cset_d    = cset_q;
    body_d    = body_q;
    hsize_d   = hsize_q;
    ctype_d   = ctype_q;
    csub_d    = csub_q;
    stop_d    = stop_q;
    len_new    = '0;
    nidx_inc   = nidx_q + 15'd1;
    skip_dec   = (skip_q != '0) ? skip_q - 15'd1 : skip_q;
    data_start = 1'b0;
    emit       = 1'b0;
    job_valid_o = 1'b0;
    job_o       = '0;

    if (accept_i) begin
      case (pos_q)
        16'd0: body_d = {header_byte_i, 20'd0};
        16'd1: body_d = body_q | {8'd0, header_byte_i, 12'd0};
        16'd2: body_d = body_q | {16'd0, header_byte_i, 4'd0};
        16'd3: begin
          body_d  = body_q | {24'd0, header_byte_i[7:4]};
          hsize_d = {header_byte_i[3:0], 9'd0};
        end
        16'd4: hsize_d = hsize_q | {4'd0, header_byte_i, 1'b0};
        16'd5: begin
          hsize_d = hsize_q | {12'd0, header_byte_i[7]};
          ctype_d = header_byte_i[6:1];
          csub_d  = {header_byte_i[0], 8'd0};
        end
        16'd6: csub_d = csub_q | {1'b0, header_byte_i};
        default: begin
          if (!stop_q) begin
            if (pos_q >= {3'd0, hsize_q}) begin
              stop_d = 1'b1;
            end else begin
              unique case (phase_q)
                PhParam: begin
                  case (header_byte_i[7:6])
                    PliOne: begin
                      skip_d  = 15'd1;
                      phase_d = PhSkip;
                    end
                    PliFour: begin
                      skip_d  = 15'd4;
                      phase_d = PhSkip;
                    end
                    PliVar: begin
                      is_name_d = (header_byte_i[5:0] == NameParamId);
                      phase_d   = PhLen1;
                    end
                    default: ;
                  endcase
                end
                PhLen1: begin
                  len_new = {8'd0, header_byte_i[6:0]};
                  plen_d  = len_new;
                  if (header_byte_i[7]) begin
                    phase_d = PhLen2;
                  end else begin
                    data_start = 1'b1;
                  end
                end
                PhLen2: begin
                  len_new    = {plen_q[6:0], header_byte_i};
                  plen_d     = len_new;
                  data_start = 1'b1;
                end
                PhCharset: begin
                  cset_d  = header_byte_i[7:4];
                  nidx_d  = 15'd1;
                  phase_d = (plen_q <= 15'd1) ? PhParam : PhName;
                end
                PhName: begin
                  emit   = (nidx_q < NameSlotEnd) && (nidx_q <= {9'd0, limit_q});
                  nidx_d = nidx_inc;
                  if (nidx_inc >= plen_q) begin
                    phase_d = PhParam;
                  end
                end
                PhSkip: begin
                  skip_d = skip_dec;
                  if (skip_dec == '0) begin
                    phase_d = PhParam;
                  end
                end
                default: phase_d = PhParam;
              endcase

              // parameter data follows the length field
              if (data_start) begin
                if (len_new == '0) begin
                  phase_d = PhParam;
                end else if (is_name_q) begin
                  phase_d = PhCharset;
                end else begin
                  skip_d  = len_new;
                  phase_d = PhSkip;
                end
              end
            end
          end
        end
      endcase

      if (pos_q != '1) begin
        pos_d = pos_q + 16'd1;
      end

      job_valid_o           = emit || segment_end_i;
      job_o.has_name        = emit;
      job_o.has_sum         = segment_end_i;
      job_o.name_char       = header_byte_i;
      job_o.char_set        = cset_d;
      job_o.body_size       = body_d;
      job_o.header_size     = hsize_d;
      job_o.content_type    = ctype_d;
      job_o.content_subtype = csub_d;

      if (segment_end_i) begin
        pos_d     = '0;
        phase_d   = PhParam;
        skip_d    = '0;
        plen_d    = '0;
        is_name_d = 1'b0;
        nidx_d    = '0;
        cset_d    = '0;
        body_d    = '0;
        hsize_d   = '0;
        ctype_d   = '0;
        csub_d    = '0;
        stop_d    = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mhp_queue.sv -----
// Short job queue between the parser front end and the result back end.
// Flip-flop storage, QDepth entries from mhp_pkg.
`default_nettype none

module mhp_queue import mhp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  job_t      wr_data_i,
  output logic      full_o,
  input  wire logic rd_i,
  output job_t      rd_data_o,
  output logic      empty_o
);

  job_t               mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     count_q;

  assign full_o    = (count_q == (QPtrW+1)'(QDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({wr_i, rd_i})
        2'b10:   count_q <= count_q + (QPtrW+1)'(1);
        2'b01:   count_q <= count_q - (QPtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mhp_back.sv -----
// Back end of the MOT header parser: takes jobs from the queue and shows them
// as one or two result items in an output register. Uses mhp_pkg.
`default_nettype none

module mhp_back import mhp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_empty_i,
  input  job_t        q_data_i,
  output logic        q_rd_o,
  input  wire logic   pop,
  output logic        empty,
  output logic        result_kind_o,
  output logic [7:0]  name_char_o,
  output logic [3:0]  char_set_o,
  output logic [27:0] body_size_o,
  output logic [12:0] header_size_o,
  output logic [5:0]  content_type_o,
  output logic [8:0]  content_subtype_o,
  output logic        last_of_run_o
);

  logic valid_q, valid_d;
  job_t job_q, job_d;
  logic take;

  always_comb begin
    valid_d = valid_q;
    job_d   = job_q;
    take    = 1'b0;
    if (valid_q && pop && job_q.has_name && job_q.has_sum) begin
      // name item gone, summary of the same byte follows
      job_d.has_name = 1'b0;
    end else if (!valid_q || pop) begin
      take    = !q_empty_i;
      valid_d = !q_empty_i;
      job_d   = q_data_i;
    end
  end

  assign q_rd_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign empty             = !valid_q;
  assign result_kind_o     = !job_q.has_name;
  assign name_char_o       = job_q.has_name ? job_q.name_char : 8'd0;
  assign char_set_o        = job_q.char_set;
  assign body_size_o       = job_q.body_size;
  assign header_size_o     = job_q.header_size;
  assign content_type_o    = job_q.content_type;
  assign content_subtype_o = job_q.content_subtype;
  assign last_of_run_o     = !(job_q.has_name && job_q.has_sum);

endmodule

`default_nettype wire

// ----- hw/rtl/mot_header_parser.sv -----
// MOT header parser: how to use the block.
// Input queue side: drive header_byte_i / segment_end_i and raise push; a byte
// is taken on a clock edge with push high and full low. Bytes 0..6 give the
// header core; later bytes below the header size are walked as extension
// parameters. Content name bytes come out as kind 0 items (up to
// name_char_limit per name); the byte flagged segment_end_i also yields a
// kind 1 summary item, after any name item of the same byte.
// Output queue side: while empty is low the oldest item is on the result
// ports; it is taken on a clock edge with pop high.
// Throughput: one byte per cycle while full is low. A byte that makes two
// items holds the output register for both in turn. An item passes from the
// edge that takes its byte through the queue write, then the output register.
// Between front and back sits a 4-entry job queue; when the receiver stalls,
// jobs pile up there and full rises once it holds four.
// name_char_limit_i is written on any edge with name_char_limit_we_i high.
// Reset (rst_ni low, asynchronous) clears the parse state and queue, and sets
// the name limit to 63.
`default_nettype none

module mot_header_parser import mhp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        name_char_limit_we_i,
  input  wire logic [5:0]  name_char_limit_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  header_byte_i,
  input  wire logic        segment_end_i,
  input  wire logic        pop,
  output logic             empty,
  output logic             result_kind_o,
  output logic [7:0]       name_char_o,
  output logic [3:0]       char_set_o,
  output logic [27:0]      body_size_o,
  output logic [12:0]      header_size_o,
  output logic [5:0]       content_type_o,
  output logic [8:0]       content_subtype_o,
  output logic             last_of_run_o
);

  logic accept;
  logic job_valid;
  job_t job;
  logic q_full, q_empty, q_rd;
  job_t q_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  mhp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_we_i    (name_char_limit_we_i),
    .limit_i       (name_char_limit_i),
    .accept_i      (accept),
    .header_byte_i (header_byte_i),
    .segment_end_i (segment_end_i),
    .job_valid_o   (job_valid),
    .job_o         (job)
  );

  mhp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_valid),
    .wr_data_i (job),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  mhp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_data),
    .q_rd_o            (q_rd),
    .pop               (pop),
    .empty             (empty),
    .result_kind_o     (result_kind_o),
    .name_char_o       (name_char_o),
    .char_set_o        (char_set_o),
    .body_size_o       (body_size_o),
    .header_size_o     (header_size_o),
    .content_type_o    (content_type_o),
    .content_subtype_o (content_subtype_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/mhp_checker.sv -----
// Port-level checks for mot_header_parser, attached by the bind below.
// Sees only the top level's ports; uses nothing else.
`default_nettype none

module mhp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic        result_kind_o,
  input wire logic [7:0]  name_char_o,
  input wire logic [3:0]  char_set_o,
  input wire logic [27:0] body_size_o,
  input wire logic        last_of_run_o
);

  // a waiting item holds while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_kind_o) && $stable(name_char_o)
                          && $stable(last_of_run_o)))
    else $error("result item changed while stalled");

  // a name item that is not last of its byte is followed by that byte's summary
  a_sum_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !result_kind_o && !last_of_run_o)
      |=> (!empty && result_kind_o && last_of_run_o))
    else $error("summary missing after name item");

  // a summary closes its byte's run and carries no name byte
  a_sum_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o) |-> (last_of_run_o && name_char_o == 8'd0))
    else $error("malformed summary item");

  // the summary after a name item repeats its charset and body size
  a_sum_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !result_kind_o && !last_of_run_o)
      |=> (char_set_o == $past(char_set_o) && body_size_o == $past(body_size_o)))
    else $error("summary fields differ from its name item");

endmodule

bind mot_header_parser mhp_checker u_mhp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pop           (pop),
  .empty         (empty),
  .result_kind_o (result_kind_o),
  .name_char_o   (name_char_o),
  .char_set_o    (char_set_o),
  .body_size_o   (body_size_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
